// ===== design/dhm_pkg.sv =====
// shared types, constants and helpers for the health monitor table
// used by dhm_cell and driver_health_monitor_table_unit; no dependencies
package dhm_pkg;

    localparam int NUM_CELLS = 16;
    localparam int USED_W    = $clog2(NUM_CELLS + 1);
    localparam int ID_W      = 32;
    localparam int CNT_W     = 8;

    typedef logic [USED_W-1:0] used_t;
    typedef logic [ID_W-1:0]   id_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [1:0]        health_t;
    typedef logic [1:0]        action_t;
    typedef logic [1:0]        cfg_idx_t;

    localparam action_t ACT_REGISTER = 2'd0;
    localparam action_t ACT_REPORT   = 2'd1;
    localparam action_t ACT_QUERY    = 2'd2;

    localparam health_t ST_OPTIMAL  = 2'd0;
    localparam health_t ST_DEGRADED = 2'd1;
    localparam health_t ST_FAILED   = 2'd2;

    localparam cfg_idx_t CFG_TIMEOUT_FAIL  = 2'd0;
    localparam cfg_idx_t CFG_ERROR_FAIL    = 2'd1;
    localparam cfg_idx_t CFG_ERROR_DEGRADE = 2'd2;

    localparam cnt_t CNT_MAX = '1;

    // item travelling down the row of cells
    typedef struct packed {
        action_t op;
        id_t     key;
        logic    ok;
        logic    tmo;
        used_t   rem;     // used entries not yet passed
        logic    done;    // an earlier cell already handled the item
        health_t health;
    } tok_t;

    typedef struct packed {
        cnt_t tout_fail;
        cnt_t err_fail;
        cnt_t err_degrade;
    } lim_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == CNT_MAX) ? v : cnt_t'(v + cnt_t'(1));
    endfunction

    function automatic health_t judge(input cnt_t errs, input cnt_t touts, input lim_t lim);
        health_t r;
        r = ST_OPTIMAL;
        if (touts > lim.tout_fail || errs > lim.err_fail)
            r = ST_FAILED;
        else if (errs > lim.err_degrade)
            r = ST_DEGRADED;
        return r;
    endfunction

endpackage

// ===== design/driver_health_monitor_table_unit.sv =====
// top level of the health monitor table: row of dhm_cell entries, config
// registers, fill count and result buffering; uses dhm_pkg and dhm_cell
//
// path: an accepted item passes the 16 cells, then the pending result register and the output register
// flow: one item at a time walks the row of 16 cells; in_stall holds off new items until the result moves out
// reset: fill count zero, limits 3/10/2, no item in flight; entry contents are not cleared
module driver_health_monitor_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] agent_id,
    input  logic        was_success,
    input  logic        was_timeout,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  health,
    output logic        matched
);

    dhm_pkg::lim_t    lim_reg;
    dhm_pkg::used_t   used_reg;
    logic             busy_reg;
    logic             pend_valid_reg;
    dhm_pkg::health_t pend_health_reg;
    logic             pend_matched_reg;
    logic             out_valid_reg;
    dhm_pkg::health_t out_health_reg;
    logic             out_matched_reg;

    logic             accept;
    logic             move_out;
    logic             tail_valid;
    dhm_pkg::tok_t    tail_tok;
    dhm_pkg::tok_t    head_tok;

    logic             chain_valid [dhm_pkg::NUM_CELLS+1];
    dhm_pkg::tok_t    chain_tok   [dhm_pkg::NUM_CELLS+1];

    assign accept   = in_valid && !busy_reg;
    assign in_stall = busy_reg;
    assign move_out = pend_valid_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        head_tok.op      = action;
        head_tok.key     = agent_id;
        head_tok.ok      = was_success;
        head_tok.tmo     = was_timeout;
        head_tok.rem     = used_reg;
        head_tok.done    = 1'b0;
        head_tok.health  = dhm_pkg::ST_OPTIMAL;
    end

    assign chain_valid[0] = accept;
    assign chain_tok[0]   = head_tok;

    for (genvar k = 0; k < dhm_pkg::NUM_CELLS; k++)
    begin : g_cell
        dhm_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .lim           (lim_reg),
            .tok_in_valid  (chain_valid[k]),
            .tok_in        (chain_tok[k]),
            .tok_out_valid (chain_valid[k+1]),
            .tok_out       (chain_tok[k+1])
        );
    end

    assign tail_valid = chain_valid[dhm_pkg::NUM_CELLS];
    assign tail_tok   = chain_tok[dhm_pkg::NUM_CELLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg.tout_fail   <= 8'd3;
            lim_reg.err_fail    <= 8'd10;
            lim_reg.err_degrade <= 8'd2;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                dhm_pkg::CFG_TIMEOUT_FAIL:  lim_reg.tout_fail   <= cfg_data;
                dhm_pkg::CFG_ERROR_FAIL:    lim_reg.err_fail    <= cfg_data;
                dhm_pkg::CFG_ERROR_DEGRADE: lim_reg.err_degrade <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // an append reports matched only when a free cell took it
            if (tail_valid && tail_tok.op == dhm_pkg::ACT_REGISTER && tail_tok.done)
                used_reg <= dhm_pkg::used_t'(used_reg + dhm_pkg::used_t'(1));

            if (accept)
                busy_reg <= 1'b1;
            else if (move_out)
                busy_reg <= 1'b0;

            if (tail_valid)
                pend_valid_reg <= 1'b1;
            else if (move_out)
                pend_valid_reg <= 1'b0;

            if (move_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_valid)
        begin
            pend_health_reg  <= tail_tok.health;
            pend_matched_reg <= tail_tok.done;
        end
        if (move_out)
        begin
            out_health_reg  <= pend_health_reg;
            out_matched_reg <= pend_matched_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign health    = out_health_reg;
    assign matched   = out_matched_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= dhm_pkg::used_t'(dhm_pkg::NUM_CELLS))
        else $error("fill count above table size");

    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid |-> busy_reg && !pend_valid_reg)
        else $error("item left the cell row while not in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && !accept)
        else $error("second item taken while one is in flight");

    a_nomatch_optimal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_matched_reg) |-> out_health_reg == dhm_pkg::ST_OPTIMAL)
        else $error("unmatched result carries a status");

endmodule

// ===== design/dhm_cell.sv =====
// one table entry: id, error and timeout counters, status
// acts on the passing item and registers it toward the next cell; uses dhm_pkg
module dhm_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  dhm_pkg::lim_t  lim,
    input  logic           tok_in_valid,
    input  dhm_pkg::tok_t  tok_in,
    output logic           tok_out_valid,
    output dhm_pkg::tok_t  tok_out
);

    dhm_pkg::id_t     id_reg;
    dhm_pkg::cnt_t    err_reg;
    dhm_pkg::cnt_t    tout_reg;
    dhm_pkg::health_t health_reg;

    logic             tok_valid_reg;
    dhm_pkg::tok_t    tok_reg;
    dhm_pkg::tok_t    tok_next;

    logic             used;
    logic             hit;
    logic             do_write;
    logic             do_report;
    dhm_pkg::cnt_t    err_next;
    dhm_pkg::cnt_t    tout_next;
    dhm_pkg::health_t verdict;
    dhm_pkg::health_t health_next;

    always_comb
    begin
        used      = (tok_in.rem != '0);
        hit       = used && !tok_in.done && (id_reg == tok_in.key) &&
                    (tok_in.op == dhm_pkg::ACT_REPORT || tok_in.op == dhm_pkg::ACT_QUERY);
        // append lands in the first unused cell
        do_write  = !used && !tok_in.done && (tok_in.op == dhm_pkg::ACT_REGISTER);
        do_report = hit && (tok_in.op == dhm_pkg::ACT_REPORT);

        err_next  = err_reg;
        tout_next = tout_reg;
        if (!tok_in.ok)
        begin
            err_next = dhm_pkg::sat_inc(err_reg);
            if (tok_in.tmo)
                tout_next = dhm_pkg::sat_inc(tout_reg);
        end
        verdict     = dhm_pkg::judge(err_next, tout_next, lim);
        health_next = (verdict > health_reg) ? verdict : health_reg;

        tok_next     = tok_in;
        tok_next.rem = used ? dhm_pkg::used_t'(tok_in.rem - dhm_pkg::used_t'(1)) : tok_in.rem;
        if (do_write)
        begin
            tok_next.done   = 1'b1;
            tok_next.health = dhm_pkg::ST_OPTIMAL;
        end
        else if (hit)
        begin
            tok_next.done   = 1'b1;
            tok_next.health = do_report ? health_next : health_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in_valid && do_write)
        begin
            id_reg     <= tok_in.key;
            err_reg    <= '0;
            tout_reg   <= '0;
            health_reg <= dhm_pkg::ST_OPTIMAL;
        end
        else if (tok_in_valid && do_report)
        begin
            err_reg    <= err_next;
            tout_reg   <= tout_next;
            health_reg <= health_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else
            tok_valid_reg <= tok_in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (tok_in_valid)
            tok_reg <= tok_next;
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule
